// ===== design/periodic_task_tick_dispatcher_assert.svh =====
// ----------------------------------------------------------------------------
// Periodic task tick dispatcher: assertion macros
// Shared property forms for the dispatcher's checks, clocked on clk and
// switched off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_TICK_DISPATCHER_ASSERT_SVH
`define PERIODIC_TASK_TICK_DISPATCHER_ASSERT_SVH

// same-cycle implication
`define PTD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PTD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/ptd_pkg.sv =====
// ----------------------------------------------------------------------------
// ptd_pkg
// Types and constants shared by the periodic task tick dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package ptd_pkg;

	localparam int MAX_TASKS  = 8;
	localparam int TASK_BITS  = 3;
	localparam int WAIT_BITS  = 16;
	localparam int COUNT_BITS = 4;
	localparam int ADDR_BITS  = 2;
	localparam int DATA_BITS  = 32;

	// register addresses
	localparam logic [ADDR_BITS-1:0] ADDR_TASK_COUNT = 2'd0;

	// request opcodes
	localparam logic [2:0] OP_TICK        = 3'd0;
	localparam logic [2:0] OP_ACTIVATE    = 3'd1;
	localparam logic [2:0] OP_DEACT_INDEX = 3'd2;
	localparam logic [2:0] OP_DEACT_CUR   = 3'd3;
	localparam logic [2:0] OP_SLEEP_CUR   = 3'd4;
	localparam logic [2:0] OP_LOAD_PERIOD = 3'd5;

	typedef struct packed {
		logic [2:0]           opcode;
		logic [TASK_BITS-1:0] task_index;
		logic [WAIT_BITS-1:0] tick_value;
	} ptd_req_t;

	typedef struct packed {
		logic [TASK_BITS-1:0] dispatched_task;
		logic                 last_dispatch;
	} ptd_res_t;

	// command broadcast to every cell
	typedef struct packed {
		logic                 valid;
		logic [2:0]           op;
		logic [WAIT_BITS-1:0] value;
	} ptd_cmd_t;

	// per-cell selects
	typedef struct packed {
		logic in_use;
		logic idx_match;
		logic cur_match;
	} ptd_sel_t;

endpackage

`default_nettype wire

// ===== design/ptd_cell.sv =====
// ----------------------------------------------------------------------------
// ptd_cell
// One task entry: ready flag, wait counter and reload period. A scan token
// enters from the left neighbour and leaves to the right in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tok_in,
	input  ptd_pkg::ptd_cmd_t cmd,
	input  ptd_pkg::ptd_sel_t sel,
	output logic              tok_out,
	output logic              hit
);
	import ptd_pkg::*;

	logic                 tok_q;
	logic                 ready_q;
	logic [WAIT_BITS-1:0] wait_q;
	logic [WAIT_BITS-1:0] period_q;
	logic [WAIT_BITS-1:0] wait_dec;
	logic                 scan;

	// scan evaluation while holding the token
	always_comb begin
		scan     = tok_q & sel.in_use & ready_q;
		wait_dec = (wait_q != '0) ? (wait_q - {{(WAIT_BITS-1){1'b0}}, 1'b1}) : wait_q;
		hit      = scan && (wait_dec == '0);
	end

	assign tok_out = tok_q;

	// entry state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q    <= 1'b0;
			ready_q  <= 1'b0;
			wait_q   <= '0;
			period_q <= '0;
		end else begin
			tok_q <= tok_in;
			if (scan) begin
				wait_q <= hit ? period_q : wait_dec;
			end
			if (cmd.valid) begin
				case (cmd.op)
					OP_ACTIVATE: begin
						if (sel.idx_match && sel.in_use) ready_q <= 1'b1;
					end
					OP_DEACT_INDEX: begin
						if (sel.idx_match && sel.in_use) ready_q <= 1'b0;
					end
					OP_DEACT_CUR: begin
						if (sel.cur_match) ready_q <= 1'b0;
					end
					OP_SLEEP_CUR: begin
						if (sel.cur_match) wait_q <= cmd.value;
					end
					OP_LOAD_PERIOD: begin
						if (sel.idx_match) begin
							period_q <= cmd.value;
							wait_q   <= cmd.value;
						end
					end
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/periodic_task_tick_dispatcher.sv =====
// ----------------------------------------------------------------------------
// Periodic task tick dispatcher
// Task table held as a row of cells, scanned by a token on each tick.
// ----------------------------------------------------------------------------
// A tick request raises busy while a scan token walks the row of task
// cells one cell per cycle, then the flush register flush_q closes
// the tick. Each dispatched task comes out on result for a single
// cycle with result_valid high, at most one per cycle, in index order; the
// one flagged last_dispatch arrives in the cycle busy drops. Results cannot
// be held off. Every other request is done at its accepting edge and busy
// stays low, so another request may follow in the next cycle.
`default_nettype none

module periodic_task_tick_dispatcher (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// request channel
	input  logic                                 start,
	output logic                                 busy,
	input  ptd_pkg::ptd_req_t                    request,
	// result channel
	output logic                                 result_valid,
	output ptd_pkg::ptd_res_t                    result,
	// configuration port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [ptd_pkg::ADDR_BITS-1:0]        paddr,
	input  logic [ptd_pkg::DATA_BITS-1:0]        pwdata,
	output logic [ptd_pkg::DATA_BITS-1:0]        prdata,
	output logic                                 pready
);
	import ptd_pkg::*;

	logic [COUNT_BITS-1:0] task_count_q;
	logic [COUNT_BITS-1:0] active_n;
	logic [TASK_BITS-1:0]  current_q;
	logic [TASK_BITS-1:0]  pend_q;
	logic                  pend_valid_q;
	logic                  flush_q;
	logic                  result_valid_q;
	ptd_res_t              result_q;
	logic [MAX_TASKS-1:0]  tok;
	logic [MAX_TASKS-1:0]  hit;
	logic                  hit_any;
	logic [TASK_BITS-1:0]  hit_idx;
	logic                  accept;
	logic                  tick_start;
	ptd_cmd_t              cmd;

	// configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= '0;
		end else if (psel && penable && pwrite && (paddr == ADDR_TASK_COUNT)) begin
			task_count_q <= pwdata[COUNT_BITS-1:0];
		end
	end

	assign prdata = (paddr == ADDR_TASK_COUNT) ?
		{{(DATA_BITS-COUNT_BITS){1'b0}}, task_count_q} : '0;

	// request decode
	always_comb begin
		accept     = start & ~busy;
		tick_start = accept & (request.opcode == OP_TICK);
		cmd.valid  = accept & (request.opcode != OP_TICK);
		cmd.op     = request.opcode;
		cmd.value  = request.tick_value;
		active_n   = (task_count_q > COUNT_BITS'(MAX_TASKS)) ?
			COUNT_BITS'(MAX_TASKS) : task_count_q;
	end

	// row of task cells
	for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
		ptd_sel_t sel;
		logic     tok_in;

		assign sel.in_use    = COUNT_BITS'(g) < active_n;
		assign sel.idx_match = request.task_index == TASK_BITS'(g);
		assign sel.cur_match = current_q == TASK_BITS'(g);

		if (g == 0) begin : g_head
			assign tok_in = tick_start;
		end else begin : g_link
			assign tok_in = tok[g-1];
		end

		ptd_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_in (tok_in),
			.cmd    (cmd),
			.sel    (sel),
			.tok_out(tok[g]),
			.hit    (hit[g])
		);
	end

	// index of the cell that dispatched (token is one-hot)
	always_comb begin
		hit_any = |hit;
		hit_idx = '0;
		for (int i = 0; i < MAX_TASKS; i++) begin
			if (hit[i]) hit_idx = TASK_BITS'(i);
		end
	end

	assign busy = (|tok) | flush_q;

	// pending dispatch: held back one hit so the last one can be flagged
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_q      <= '0;
			pend_valid_q   <= 1'b0;
			flush_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			flush_q        <= tok[MAX_TASKS-1];
			result_valid_q <= 1'b0;
			if (hit_any) begin
				current_q      <= hit_idx;
				pend_valid_q   <= 1'b1;
				result_valid_q <= pend_valid_q;
			end else if (flush_q) begin
				pend_valid_q   <= 1'b0;
				result_valid_q <= pend_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit_any) begin
			pend_q                   <= hit_idx;
			result_q.dispatched_task <= pend_q;
			result_q.last_dispatch   <= 1'b0;
		end else if (flush_q) begin
			result_q.dispatched_task <= pend_q;
			result_q.last_dispatch   <= 1'b1;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// checks
	`include "periodic_task_tick_dispatcher_assert.svh"

	`PTD_ASSERT_NOW(a_tok_onehot, 1'b1, $onehot0(tok), "more than one scan token")
	`PTD_ASSERT_NOW(a_res_in_scan, result_valid, $past(busy), "result outside a tick")
	`PTD_ASSERT_NOW(a_last_idle, result_valid && result.last_dispatch, !busy, "last result while busy")
	`PTD_ASSERT_NEXT(a_tick_busy, tick_start, busy, "tick did not start a scan")

endmodule

`default_nettype wire

// ===== bench/ptd_dispatch_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dispatch checker for the periodic task tick dispatcher
// Watches the request, result and configuration channels, keeps its own copy
// of the task table, predicts the dispatches of every tick and compares each
// result against the oldest prediction. Counts are handed to the bench top.
// ----------------------------------------------------------------------------

module ptd_dispatch_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  ptd_pkg::ptd_req_t             request,
	input  logic                          result_valid,
	input  ptd_pkg::ptd_res_t             result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ptd_pkg::ADDR_BITS-1:0] paddr,
	input  logic [ptd_pkg::DATA_BITS-1:0] pwdata,
	input  logic [ptd_pkg::DATA_BITS-1:0] prdata,
	input  logic                          pready,
	output int                            mismatches,
	output int                            outstanding,
	output int                            requests_seen,
	output int                            dispatches_seen
);
	import ptd_pkg::*;

	// shadow task table
	logic                  ready_q   [MAX_TASKS];
	logic [WAIT_BITS-1:0]  countdown [MAX_TASKS];
	logic [WAIT_BITS-1:0]  reload    [MAX_TASKS];
	logic [TASK_BITS-1:0]  last_run;
	logic [COUNT_BITS-1:0] tasks_in_use;

	ptd_res_t due_dispatches [$];
	ptd_res_t oldest;
	int       fail_tally;
	int       req_tally;
	int       disp_tally;

	task automatic clear_table();
		for (int i = 0; i < MAX_TASKS; i++) begin
			ready_q[i]   = 1'b0;
			countdown[i] = '0;
			reload[i]    = '0;
		end
		last_run     = '0;
		tasks_in_use = '0;
	endtask

	// apply one accepted request to the shadow table, queueing any dispatches
	task automatic advance_table(input ptd_req_t req);
		int unsigned span;
		int          picked [$];
		ptd_res_t    hit;
		span = (tasks_in_use > MAX_TASKS) ? MAX_TASKS : tasks_in_use;
		case (req.opcode)
			OP_TICK: begin
				for (int i = 0; i < span; i++) begin
					if (ready_q[i]) begin
						if (countdown[i] != '0)
							countdown[i] = countdown[i] - 1'b1;
						if (countdown[i] == '0) begin
							last_run     = TASK_BITS'(i);
							countdown[i] = reload[i];
							picked.push_back(i);
						end
					end
				end
				for (int k = 0; k < picked.size(); k++) begin
					hit.dispatched_task = TASK_BITS'(picked[k]);
					hit.last_dispatch   = (k == picked.size() - 1);
					due_dispatches.push_back(hit);
				end
			end
			OP_ACTIVATE: begin
				if (req.task_index < span)
					ready_q[req.task_index] = 1'b1;
			end
			OP_DEACT_INDEX: begin
				if (req.task_index < span)
					ready_q[req.task_index] = 1'b0;
			end
			// current task may sit beyond the count in use
			OP_DEACT_CUR: ready_q[last_run] = 1'b0;
			OP_SLEEP_CUR: countdown[last_run] = req.tick_value;
			OP_LOAD_PERIOD: begin
				reload[req.task_index]    = req.tick_value;
				countdown[req.task_index] = req.tick_value;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_table();
			due_dispatches.delete();
			fail_tally = 0;
			req_tally  = 0;
			disp_tally = 0;
		end else begin
			// results first: a new tick only appends behind them
			if (result_valid) begin
				if (due_dispatches.size() == 0) begin
					$error("unexpected dispatch: task %0d last %0b",
						result.dispatched_task, result.last_dispatch);
					fail_tally++;
				end else begin
					oldest = due_dispatches.pop_front();
					if (result.dispatched_task !== oldest.dispatched_task) begin
						$error("dispatched_task mismatch: expected %0d, got %0d",
							oldest.dispatched_task, result.dispatched_task);
						fail_tally++;
					end
					if (result.last_dispatch !== oldest.last_dispatch) begin
						$error("last_dispatch mismatch: expected %0b, got %0b",
							oldest.last_dispatch, result.last_dispatch);
						fail_tally++;
					end
					disp_tally++;
				end
			end
			if (start && !busy) begin
				advance_table(request);
				req_tally++;
			end
			// register writes and read-back
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr == ADDR_TASK_COUNT)
						tasks_in_use = pwdata[COUNT_BITS-1:0];
				end else if (paddr == ADDR_TASK_COUNT &&
						prdata !== DATA_BITS'(tasks_in_use)) begin
					$error("task_count mismatch: expected %0d, got %0d",
						tasks_in_use, prdata);
					fail_tally++;
				end
			end
		end
		mismatches      <= fail_tally;
		outstanding     <= due_dispatches.size();
		requests_seen   <= req_tally;
		dispatches_seen <= disp_tally;
	end

endmodule

// ===== bench/periodic_task_tick_dispatcher_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Periodic task tick dispatcher testbench
// Drives a directed set of requests, then random request mixes over several
// task counts and sender idle rates; the dispatch checker predicts and
// compares every result and this top gives the verdict.
// ----------------------------------------------------------------------------

module periodic_task_tick_dispatcher_tb;
	import ptd_pkg::*;

	// opcodes the block leaves unused
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	localparam int SETTLE_CYCLES    = MAX_TASKS + 3;
	localparam int DRAIN_LIMIT      = 2000;
	localparam int RANDOM_PER_PHASE = 75;

	logic                 clk     = 1'b0;
	logic                 arst_n  = 1'b0;
	logic                 start   = 1'b0;
	ptd_req_t             request = '0;
	logic                 busy;
	logic                 result_valid;
	ptd_res_t             result;
	logic                 psel    = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite  = 1'b0;
	logic [ADDR_BITS-1:0] paddr   = '0;
	logic [DATA_BITS-1:0] pwdata  = '0;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;

	int mismatches;
	int outstanding;
	int requests_seen;
	int dispatches_seen;
	int sender_idle_pct = 0;

	always #6 clk = ~clk;

	periodic_task_tick_dispatcher dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	ptd_dispatch_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.request         (request),
		.result_valid    (result_valid),
		.result          (result),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.requests_seen   (requests_seen),
		.dispatches_seen (dispatches_seen)
	);

	function automatic ptd_req_t make_request(input logic [2:0] op,
			input int unsigned idx, input int unsigned val);
		ptd_req_t req;
		req.opcode     = op;
		req.task_index = TASK_BITS'(idx);
		req.tick_value = WAIT_BITS'(val);
		return req;
	endfunction

	// mostly ticks and table set-up with short periods, a few wide values
	function automatic ptd_req_t random_request();
		ptd_req_t    req;
		int unsigned roll;
		roll           = $urandom_range(99);
		req.task_index = TASK_BITS'($urandom_range(MAX_TASKS - 1));
		req.tick_value = ($urandom_range(9) == 0) ? WAIT_BITS'($urandom)
			: WAIT_BITS'($urandom_range(6));
		if (roll < 45)
			req.opcode = OP_TICK;
		else if (roll < 60)
			req.opcode = OP_ACTIVATE;
		else if (roll < 68)
			req.opcode = OP_DEACT_INDEX;
		else if (roll < 73)
			req.opcode = OP_DEACT_CUR;
		else if (roll < 80)
			req.opcode = OP_SLEEP_CUR;
		else if (roll < 94)
			req.opcode = OP_LOAD_PERIOD;
		else if (roll < 97)
			req.opcode = OP_SPARE_LO;
		else
			req.opcode = OP_SPARE_HI;
		return req;
	endfunction

	// hold start until the request is taken; idle cycles go before it
	task automatic issue(input ptd_req_t req);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		request <= req;
		do @(posedge clk); while (busy);
	endtask

	// wait for every predicted dispatch, then for a tick with none to finish
	task automatic settle();
		int guard;
		guard = 0;
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [DATA_BITS-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= ADDR_TASK_COUNT;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_task_count(input logic [DATA_BITS-1:0] data);
		settle();
		apb_access(1'b1, data);
		@(posedge clk);
		apb_access(1'b0, '0);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: nothing in use after reset
		set_task_count('0);
		issue(make_request(OP_TICK, 0, 0));
		issue(make_request(OP_ACTIVATE, 0, 0));
		issue(make_request(OP_LOAD_PERIOD, 2, 1));

		// directed: full table, zero and extreme periods
		set_task_count(DATA_BITS'(MAX_TASKS));
		issue(make_request(OP_LOAD_PERIOD, 0, 0));
		issue(make_request(OP_LOAD_PERIOD, 1, 1));
		issue(make_request(OP_LOAD_PERIOD, 3, 2));
		issue(make_request(OP_LOAD_PERIOD, 7, 16'hFFFF));
		issue(make_request(OP_LOAD_PERIOD, 6, 0));
		issue(make_request(OP_ACTIVATE, 0, 0));
		issue(make_request(OP_ACTIVATE, 1, 0));
		issue(make_request(OP_ACTIVATE, 3, 0));
		issue(make_request(OP_ACTIVATE, 6, 0));
		issue(make_request(OP_ACTIVATE, 7, 0));
		issue(make_request(OP_ACTIVATE, 2, 0));
		issue(make_request(OP_TICK, 0, 0));
		issue(make_request(OP_TICK, 0, 0));
		issue(make_request(OP_DEACT_CUR, 0, 0));
		issue(make_request(OP_SLEEP_CUR, 0, 16'hFFFF));
		issue(make_request(OP_DEACT_INDEX, 1, 0));
		issue(make_request(OP_SPARE_LO, 7, 16'hFFFF));
		issue(make_request(OP_SPARE_HI, 5, 16'h5A5A));
		issue(make_request(OP_ACTIVATE, 6, 0));
		issue(make_request(OP_LOAD_PERIOD, 6, 0));
		issue(make_request(OP_TICK, 0, 0));

		// directed: current task left beyond a reduced count
		set_task_count(32'd3);
		issue(make_request(OP_ACTIVATE, 5, 0));
		issue(make_request(OP_DEACT_INDEX, 4, 0));
		issue(make_request(OP_LOAD_PERIOD, 7, 5));
		issue(make_request(OP_DEACT_CUR, 0, 0));
		issue(make_request(OP_SLEEP_CUR, 0, 16'h8000));
		issue(make_request(OP_TICK, 0, 0));

		// random phases over counts and sender idle rates
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct = 0;
					set_task_count(DATA_BITS'(MAX_TASKS));
				end
				1: begin
					sender_idle_pct = 80;
					set_task_count('1);
				end
				2: begin
					sender_idle_pct = 0;
					set_task_count(32'd5);
				end
				default: begin
					sender_idle_pct = 36;
					set_task_count({16'($urandom_range(16'hFFFF)), 12'h0,
						COUNT_BITS'($urandom_range(1, MAX_TASKS))});
				end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				issue(random_request());
		end

		settle();
		$display("Run covered %0d requests and %0d dispatch results", requests_seen,
			dispatches_seen);
		$display("over task counts 0, 3, 5, 8, 15 and one random, idle 0/36/80 percent");
		if (outstanding != 0)
			$error("dispatch results never arrived: %0d", outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/ptd_pkg.sv
design/ptd_cell.sv
design/periodic_task_tick_dispatcher.sv
bench/ptd_dispatch_checker.sv
bench/periodic_task_tick_dispatcher_tb.sv
